// ===== hdl/gjan_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the glove joint normalizer.
// Depends on nothing; every other file of the block imports it.
package gjan_pkg;

  localparam int NUM_GROUPS       = 6;
  localparam int JOINTS_PER_GROUP = 3;
  localparam int FRAC_BITS        = 12;

  localparam int VAL_W   = 16;
  localparam int GRP_W   = 3;
  localparam int POS_W   = 13;

  localparam int READINGS     = 3;
  localparam int WRIST_JOINTS = 2;
  localparam int FINGER_CNT   = (JOINTS_PER_GROUP < READINGS) ? JOINTS_PER_GROUP : READINGS;
  localparam int WRIST_CNT    = (FINGER_CNT < WRIST_JOINTS) ? FINGER_CNT : WRIST_JOINTS;

  localparam int ENTRIES = NUM_GROUPS * JOINTS_PER_GROUP;
  localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int J_W     = $clog2(READINGS);
  localparam int CNT_W   = $clog2(READINGS + 1);

  localparam int FRAC1_W = FRAC_BITS + 1;
  localparam int SUM_W   = FRAC_BITS + 2;
  localparam int DIV_W   = VAL_W;
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int CLAMP_W = (SUM_W > VAL_W) ? SUM_W : VAL_W;

  localparam logic [FRAC1_W-1:0] UNIT_VALUE = FRAC1_W'(1) << FRAC_BITS;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [GRP_W-1:0]        grp_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [ENTRY_W-1:0]      entry_t;
  typedef logic [FRAC1_W-1:0]      frac_t;

  // Request into the calibration store.
  typedef struct packed {
    logic   clear;
    logic   wr;
    entry_t idx;
    val_t   value;
  } calib_req_t;

  // Request into the serial divider.
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem_init;
    logic [SUM_W-1:0]  dividend;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  // Limit a nonnegative fraction to 1.0.
  function automatic frac_t clamp_unit(input logic [CLAMP_W-1:0] q);
    frac_t r;
    if (q > CLAMP_W'(UNIT_VALUE)) begin
      r = UNIT_VALUE;
    end else begin
      r = FRAC1_W'(q);
    end
    return r;
  endfunction

endpackage

// ===== hdl/gjan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample items and result items.
// Depends on gjan_pkg for field types.
interface gjan_in_if import gjan_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  grp_t group;
  val_t joint_value_a;
  val_t joint_value_b;
  val_t joint_value_c;

  modport source (output valid, operation, group, joint_value_a, joint_value_b,
                  joint_value_c, input ready);
  modport sink   (input valid, operation, group, joint_value_a, joint_value_b,
                  joint_value_c, output ready);
endinterface

interface gjan_out_if import gjan_pkg::*; ();
  logic valid;
  logic ready;
  grp_t group_out;
  pos_t position_out;
  logic was_reset;

  modport source (output valid, group_out, position_out, was_reset, input ready);
  modport sink   (input valid, group_out, position_out, was_reset, output ready);
endinterface

// ===== hdl/gjan_calib.sv =====
`timescale 1ns / 1ps
// Calibration store: running minimum and maximum of every joint.
// Depends on gjan_pkg.
module gjan_calib import gjan_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  calib_req_t req,
  output val_t       rd_min,
  output val_t       rd_max
);

  val_t min_r [ENTRIES];
  val_t max_r [ENTRIES];

  // A write widens the addressed entry with the reading.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      for (int i = 0; i < ENTRIES; i++) begin
        min_r[i] <= val_t'(UNIT_VALUE);
        max_r[i] <= '0;
      end
    end else if (req.wr) begin
      if (req.value < min_r[req.idx]) begin
        min_r[req.idx] <= req.value;
      end
      if (req.value > max_r[req.idx]) begin
        max_r[req.idx] <= req.value;
      end
    end
  end

  assign rd_min = min_r[req.idx];
  assign rd_max = max_r[req.idx];

endmodule

// ===== hdl/gjan_div.sv =====
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
// Depends on gjan_pkg.
module gjan_div import gjan_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.rem_init;
      dvd_nxt  = req.dividend;
      quo_nxt  = '0;
      dsr_nxt  = req.divisor;
      step_nxt = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the trial fits DIV_W+1 bits.
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      dvd_nxt  = {dvd_r[SUM_W-2:0], 1'b0};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    dsr_r  <= dsr_nxt;
    step_r <= step_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/glove_joint_autocal_normalizer_core.sv =====
`timescale 1ns / 1ps
// Throughput: one item at a time; the single serial divider, one quotient bit per
// cycle, serves every joint and the mean. A new item is taken the cycle after the
// result is registered.
// Reset: rst_n is synchronous and active low; it clears the sequencer and the output
// register and loads every minimum with 1.0 and every maximum with zero.
module glove_joint_autocal_normalizer_core import gjan_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  gjan_in_if.sink        in_ch,
  gjan_out_if.source     out_ch
);

  // One-hot sequencer. Per joint: widen the calibration (UPD), form the
  // numerator and span (PREP), divide where needed (DIV) and add the fraction (ACC).
  // The mean then goes through the same divider (MEAN, MDIV).
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_UPD  = 8'b0000_0010,
    S_PREP = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_MEAN = 8'b0010_0000,
    S_MDIV = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  val_t              vals_r [READINGS];
  val_t              vals_nxt [READINGS];
  logic [J_W-1:0]    j_r, j_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  entry_t            idx_r, idx_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  frac_t             jq_r, jq_nxt;
  grp_t              res_grp_r, res_grp_nxt;
  pos_t              res_pos_r, res_pos_nxt;
  logic              res_rst_r, res_rst_nxt;
  logic              out_valid_r, out_valid_nxt;
  grp_t              out_grp_r, out_grp_nxt;
  pos_t              out_pos_r, out_pos_nxt;
  logic              out_rst_r, out_rst_nxt;

  calib_req_t        calib_req;
  div_req_t          div_req;
  val_t              rd_min;
  val_t              rd_max;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;

  logic signed [VAL_W:0] num;
  logic signed [VAL_W:0] span;
  logic                  grp_ok;
  logic                  is_wrist;

  gjan_calib u_calib (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (calib_req),
    .rd_min (rd_min),
    .rd_max (rd_max)
  );

  gjan_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // The store holds the already widened entry in PREP, so the reading never
  // falls below the minimum nor above the maximum there.
  assign num  = {vals_r[j_r][VAL_W-1], vals_r[j_r]} - {rd_min[VAL_W-1], rd_min};
  assign span = {rd_max[VAL_W-1], rd_max} - {rd_min[VAL_W-1], rd_min};

  assign grp_ok   = int'(in_ch.group) < NUM_GROUPS;
  assign is_wrist = int'(in_ch.group) == NUM_GROUPS - 1;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    vals_nxt      = vals_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    jq_nxt        = jq_r;
    res_grp_nxt   = res_grp_r;
    res_pos_nxt   = res_pos_r;
    res_rst_nxt   = res_rst_r;
    out_valid_nxt = out_valid_r;
    out_grp_nxt   = out_grp_r;
    out_pos_nxt   = out_pos_r;
    out_rst_nxt   = out_rst_r;

    calib_req       = '0;
    calib_req.idx   = idx_r;
    calib_req.value = vals_r[j_r];
    div_req         = '0;

    // The output register frees up when the sink takes the waiting item.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation == OP_RESET) begin
            calib_req.clear = 1'b1;
            res_grp_nxt     = '0;
            res_pos_nxt     = '0;
            res_rst_nxt     = 1'b1;
            state_nxt       = S_OUT;
          end else begin
            vals_nxt[0] = in_ch.joint_value_a;
            vals_nxt[1] = in_ch.joint_value_b;
            vals_nxt[2] = in_ch.joint_value_c;
            res_grp_nxt = in_ch.group;
            res_pos_nxt = '0;
            res_rst_nxt = 1'b0;
            j_nxt       = '0;
            sum_nxt     = '0;
            idx_nxt     = ENTRY_W'(in_ch.group) * ENTRY_W'(JOINTS_PER_GROUP);
            cnt_nxt     = is_wrist ? CNT_W'(WRIST_CNT) : CNT_W'(FINGER_CNT);
            // A group beyond the last one touches no calibration.
            state_nxt   = grp_ok ? S_UPD : S_OUT;
          end
        end
      end
      S_UPD: begin
        calib_req.wr = 1'b1;
        state_nxt    = S_PREP;
      end
      S_PREP: begin
        if (num[VAL_W] || (num == '0)) begin
          jq_nxt    = '0;
          state_nxt = S_ACC;
        end else if (span[VAL_W] || (span == '0)) begin
          // A zero span counts as a divisor of 1.0.
          jq_nxt    = clamp_unit(CLAMP_W'(num[VAL_W-1:0]));
          state_nxt = S_ACC;
        end else begin
          // num << FRAC_BITS over span is at most 1.0 because num <= span:
          // preload the high part and shift in the last FRAC_BITS+1 bits.
          div_req.start    = 1'b1;
          div_req.rem_init = DIV_W'(num[VAL_W-1:1]);
          div_req.dividend = {num[0], {FRAC_BITS{1'b0}}, 1'b0};
          div_req.steps    = STEP_W'(FRAC1_W);
          div_req.divisor  = span[DIV_W-1:0];
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          jq_nxt    = clamp_unit(CLAMP_W'(div_quo));
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sum_nxt = sum_r + SUM_W'(jq_r);
        if (CNT_W'(j_r) == cnt_r - CNT_W'(1)) begin
          state_nxt = S_MEAN;
        end else begin
          j_nxt     = j_r + J_W'(1);
          idx_nxt   = idx_r + ENTRY_W'(1);
          state_nxt = S_UPD;
        end
      end
      S_MEAN: begin
        // The mean is truncated, as a plain integer division by the joint count.
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.dividend = sum_r;
        div_req.steps    = STEP_W'(SUM_W);
        div_req.divisor  = DIV_W'(cnt_r);
        state_nxt        = S_MDIV;
      end
      S_MDIV: begin
        if (div_done) begin
          res_pos_nxt = POS_W'(div_quo);
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_grp_nxt   = res_grp_r;
          out_pos_nxt   = res_pos_r;
          out_rst_nxt   = res_rst_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    vals_r    <= vals_nxt;
    j_r       <= j_nxt;
    cnt_r     <= cnt_nxt;
    idx_r     <= idx_nxt;
    sum_r     <= sum_nxt;
    jq_r      <= jq_nxt;
    res_grp_r <= res_grp_nxt;
    res_pos_r <= res_pos_nxt;
    res_rst_r <= res_rst_nxt;
    out_grp_r <= out_grp_nxt;
    out_pos_r <= out_pos_nxt;
    out_rst_r <= out_rst_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.group_out    = out_grp_r;
  assign out_ch.position_out = out_pos_r;
  assign out_ch.was_reset    = out_rst_r;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for glove_joint_autocal_normalizer_core: directed and random
// sample and reset items, checked against a running min/max calibration predictor.
// Depends on gjan_pkg, gjan_in_if and gjan_out_if from the hdl folder.
module tb;
  import gjan_pkg::*;

  localparam int UNIT_ONE    = 1 << FRAC_BITS;
  localparam int RANDOM_ITEMS = 1530;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int TAIL_CYCLES  = 100;
  localparam int LONG_HOLD    = 600;
  localparam int MAX_PRINTED  = 30;

  // One item as the sender will offer it. A drain marker makes the sender wait
  // until every outstanding result has come back before it offers this item.
  typedef struct {
    logic op;
    grp_t grp;
    val_t ra;
    val_t rb;
    val_t rc;
    bit   drain_first;
  } sample_item_t;

  typedef struct {
    grp_t grp;
    pos_t pos;
    logic was_reset;
  } joint_position_t;

  logic clk;
  logic rst_n;

  gjan_in_if  in_ch ();
  gjan_out_if out_ch ();

  glove_joint_autocal_normalizer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sample_item_t    pending_items[$];
  joint_position_t expected_positions[$];

  // Calibration as the block should hold it, one entry per group and joint.
  int calib_min [ENTRIES];
  int calib_max [ENTRIES];

  int  error_count   = 0;
  int  results_seen  = 0;
  int  cycle_count   = 0;
  bit  in_fire       = 1'b0;

  // Sender burst state and receiver stall state.
  int  burst_left     = 4;
  int  gap_left       = 0;
  bit  ready_level    = 1'b1;
  int  run_left       = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 1'b0;

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    error_count++;
  endtask

  function automatic void clear_calibration();
    for (int i = 0; i < ENTRIES; i++) begin
      calib_min[i] = UNIT_ONE;
      calib_max[i] = 0;
    end
  endfunction

  // Widen each used joint's range with its reading, then take the clamped
  // fraction (reading - min) / (max - min) and average over the joints used.
  function automatic joint_position_t predict_position(input logic op, input grp_t grp,
                                                       input val_t ra, input val_t rb,
                                                       input val_t rc);
    joint_position_t r;
    int              reading [3];
    int              used;
    int              sum;
    int              idx;
    int              num;
    int              span;
    longint          q;
    r.grp       = grp;
    r.pos       = '0;
    r.was_reset = 1'b0;
    if (op == OP_RESET) begin
      clear_calibration();
      r.grp       = '0;
      r.was_reset = 1'b1;
      return r;
    end
    if (grp >= NUM_GROUPS) begin
      return r;
    end
    reading[0] = ra;
    reading[1] = rb;
    reading[2] = rc;
    used = (grp == NUM_GROUPS - 1) ? WRIST_CNT : FINGER_CNT;
    sum  = 0;
    for (int j = 0; j < used; j++) begin
      idx = grp * JOINTS_PER_GROUP + j;
      if (reading[j] < calib_min[idx]) calib_min[idx] = reading[j];
      if (reading[j] > calib_max[idx]) calib_max[idx] = reading[j];
      num  = reading[j] - calib_min[idx];
      span = calib_max[idx] - calib_min[idx];
      if (num <= 0) begin
        q = 0;
      end else if (span <= 0) begin
        // A zero span counts as a divisor of 1.0.
        q = num;
      end else begin
        q = (longint'(num) << FRAC_BITS) / span;
      end
      if (q > UNIT_ONE) q = UNIT_ONE;
      sum += int'(q);
    end
    if (used > 0) r.pos = pos_t'(sum / used);
    return r;
  endfunction

  function automatic void add_item(input logic op, input grp_t grp, input val_t ra,
                                   input val_t rb, input val_t rc, input bit drain_first);
    sample_item_t it;
    it.op          = op;
    it.grp         = grp;
    it.ra          = ra;
    it.rb          = rb;
    it.rc          = rc;
    it.drain_first = drain_first;
    pending_items.push_back(it);
  endfunction

  // Mostly readings near the calibrated window so fractions spread out, with
  // full-range words and the extremes mixed in.
  function automatic val_t random_reading();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      return val_t'($urandom_range(0, 8192) - 4096);
    end else if (kind == 6) begin
      return val_t'($urandom_range(0, UNIT_ONE));
    end else if (kind <= 8) begin
      return val_t'($urandom());
    end
    case ($urandom_range(0, 4))
      0:       return val_t'(-32768);
      1:       return val_t'(32767);
      2:       return val_t'(-1);
      3:       return val_t'(UNIT_ONE);
      default: return val_t'(0);
    endcase
  endfunction

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_SAMPLE;
    in_ch.group         = '0;
    in_ch.joint_value_a = '0;
    in_ch.joint_value_b = '0;
    in_ch.joint_value_c = '0;
    out_ch.ready        = 1'b0;
    forever #1 clk = ~clk;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Scoreboard: check results first, then record the prediction for any item
  // taken on the same edge, so an early result can never match a new item.
  always @(posedge clk) begin
    joint_position_t want;
    if (!rst_n) begin
      clear_calibration();
      in_fire <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_positions.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: group %0d pos %0d rst %0b",
                                    out_ch.group_out, out_ch.position_out, out_ch.was_reset));
        end else begin
          want = expected_positions.pop_front();
          if (out_ch.group_out !== want.grp) begin
            report_mismatch($sformatf("group_out %0d, predicted %0d",
                                      out_ch.group_out, want.grp));
          end
          if (out_ch.position_out !== want.pos) begin
            report_mismatch($sformatf("position_out %0d, predicted %0d (group %0d)",
                                      out_ch.position_out, want.pos, want.grp));
          end
          if (out_ch.was_reset !== want.was_reset) begin
            report_mismatch($sformatf("was_reset %0b, predicted %0b",
                                      out_ch.was_reset, want.was_reset));
          end
        end
      end
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        expected_positions.push_back(predict_position(in_ch.operation, in_ch.group,
                                                      in_ch.joint_value_a,
                                                      in_ch.joint_value_b,
                                                      in_ch.joint_value_c));
        void'(pending_items.pop_front());
      end
    end
  end

  // Sender: bursts of random length separated by random gaps. An offered item
  // stays on the channel until it is taken.
  always @(negedge clk) begin
    logic offer;
    offer = 1'b0;
    if (rst_n) begin
      if (in_fire) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
      if (in_ch.valid && !in_fire) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0 &&
                   (!pending_items[0].drain_first || expected_positions.size() == 0)) begin
        offer               = 1'b1;
        in_ch.operation     <= pending_items[0].op;
        in_ch.group         <= pending_items[0].grp;
        in_ch.joint_value_a <= pending_items[0].ra;
        in_ch.joint_value_b <= pending_items[0].rb;
        in_ch.joint_value_c <= pending_items[0].rc;
      end
    end
    in_ch.valid <= offer;
  end

  // Receiver: alternating ready and stall runs of random length, including long
  // always-ready stretches, plus one long hold-off once traffic is flowing.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 400) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        ready_level = ~ready_level;
        if (ready_level) begin
          run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
        end else begin
          run_left = $urandom_range(1, 30);
        end
      end
      run_left--;
      out_ch.ready <= ready_level;
    end
  end

  initial begin
    // Directed part: reset, extremes, zero span, every group, out-of-range groups.
    add_item(OP_RESET,  3'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    add_item(OP_SAMPLE, 3'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    add_item(OP_SAMPLE, 3'd0, val_t'(UNIT_ONE), 16'sd32767, -16'sd32768, 1'b0);
    add_item(OP_SAMPLE, 3'd0, 16'sd2048, 16'sd0, 16'sd0, 1'b0);
    add_item(OP_SAMPLE, 3'd1, 16'sd32767, -16'sd32768, 16'sd0, 1'b0);
    add_item(OP_SAMPLE, 3'd1, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0);
    add_item(OP_SAMPLE, 3'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    // Zero span: a reading between zero and 1.0 collapses the range to a point.
    add_item(OP_SAMPLE, 3'd2, 16'sd2048, 16'sd2048, 16'sd2048, 1'b0);
    add_item(OP_SAMPLE, 3'd2, 16'sd2048, 16'sd2048, 16'sd2048, 1'b0);
    add_item(OP_SAMPLE, 3'd2, 16'sd3000, 16'sd1000, 16'sd2048, 1'b0);
    add_item(OP_SAMPLE, 3'd3, 16'sd1000, -16'sd1, 16'sd5000, 1'b0);
    add_item(OP_SAMPLE, 3'd3, 16'sd500, 16'sd700, 16'sd4500, 1'b0);
    add_item(OP_SAMPLE, 3'd4, -16'sd1, -16'sd1, -16'sd1, 1'b0);
    add_item(OP_SAMPLE, 3'd4, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    add_item(OP_SAMPLE, 3'd4, 16'sd16383, 16'sd0, -16'sd16384, 1'b0);
    // The wrist ignores its third reading.
    add_item(OP_SAMPLE, 3'd5, -16'sd32768, 16'sd32767, 16'sd12345, 1'b0);
    add_item(OP_SAMPLE, 3'd5, 16'sd0, 16'sd0, -16'sd32768, 1'b0);
    add_item(OP_SAMPLE, 3'd6, 16'sd100, 16'sd200, 16'sd300, 1'b0);
    add_item(OP_SAMPLE, 3'd7, -16'sd32768, 16'sd32767, -16'sd1, 1'b0);
    // A reset ignores its group and readings; afterwards the ranges start over.
    add_item(OP_RESET,  3'd5, 16'sd32767, -16'sd32768, 16'sd4096, 1'b0);
    add_item(OP_SAMPLE, 3'd0, 16'sd3000, 16'sd5000, -16'sd5, 1'b0);
    add_item(OP_SAMPLE, 3'd5, 16'sd4096, 16'sd4096, 16'sd0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sample_item_t it;
      it.drain_first = (n == RANDOM_ITEMS / 2);
      it.ra          = random_reading();
      it.rb          = random_reading();
      it.rc          = random_reading();
      case ($urandom_range(0, 39))
        0: begin
          it.op  = OP_RESET;
          it.grp = grp_t'($urandom_range(0, 7));
        end
        1: begin
          it.op  = OP_SAMPLE;
          it.grp = grp_t'($urandom_range(NUM_GROUPS, 7));
        end
        default: begin
          it.op  = OP_SAMPLE;
          it.grp = grp_t'($urandom_range(0, NUM_GROUPS - 1));
        end
      endcase
      add_item(it.op, it.grp, it.ra, it.rb, it.rc, it.drain_first);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || expected_positions.size() != 0) begin
      @(posedge clk);
    end
    // Let any stray result surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== glove_joint_autocal_normalizer_core.f =====
hdl/gjan_pkg.sv
hdl/gjan_if.sv
hdl/gjan_calib.sv
hdl/gjan_div.sv
hdl/glove_joint_autocal_normalizer_core.sv
test/tb.sv
